// ===== sv/bpf_pkg.sv =====
// Package for the Bezier path flattener.
// Holds the command and term types, the opcode and class codes, and the datapath widths.
// No dependencies.
package bpf_pkg;

    localparam int COORD_W = 32;
    localparam int OP_W    = 3;
    localparam int WGT_W   = 17;
    localparam int WGT_FRAC = 16;
    localparam int PROD_W  = WGT_W + 1 + COORD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CNT_W   = 13;
    localparam int NTERM   = 4;

    localparam longint WGT_SCALE = 65536;
    localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;
    localparam logic [WGT_W-1:0] WGT_ZERO = 17'h00000;

    localparam logic [OP_W-1:0] OP_BEGIN = 3'd0;
    localparam logic [OP_W-1:0] OP_MOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LINE  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUAD  = 3'd3;
    localparam logic [OP_W-1:0] OP_CUBIC = 3'd4;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [1:0] t_cls;

    localparam t_cls CLS_BEGIN = 2'd0;
    localparam t_cls CLS_POINT = 2'd1;
    localparam t_cls CLS_QUAD  = 2'd2;
    localparam t_cls CLS_CUBIC = 2'd3;

    typedef struct packed {
        t_cls   cls;
        logic   kind;
        t_coord c1x;
        t_coord c1y;
        t_coord c2x;
        t_coord c2y;
        t_coord ex;
        t_coord ey;
    } t_cmd;

endpackage

// ===== sv/bpf_cmd_if.sv =====
// Command channel interface: valid/ready handshake plus one path command word.
// Depends on bpf_pkg.
interface bpf_cmd_if import bpf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    t_coord            ctrl1_x;
    t_coord            ctrl1_y;
    t_coord            ctrl2_x;
    t_coord            ctrl2_y;
    t_coord            end_x;
    t_coord            end_y;

    modport source (output valid, opcode, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
                    input ready);
    modport sink   (input valid, opcode, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
                    output ready);
endinterface

// ===== sv/bpf_pt_if.sv =====
// Point channel interface: valid/ready handshake plus one path point word.
// Depends on bpf_pkg.
interface bpf_pt_if import bpf_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   point_kind;
    logic   last_point;

    modport source (output valid, point_x, point_y, point_kind, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_kind, last_point, output ready);
endinterface

// ===== sv/bpf_front.sv =====
// Front end: accepts command words, classifies them and holds them in a two-entry queue.
// Depends on bpf_pkg and bpf_cmd_if.
module bpf_front import bpf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpf_cmd_if.sink       i_cmd,
    output logic          o_head_v,
    output t_cmd          o_head,
    input  logic          i_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_cmd              r_q [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [FILL_W-1:0] r_fill;
    t_cmd              n_entry;
    logic              n_valid_op;
    logic              push;
    logic              pop;

    always_comb begin
        n_entry.kind = KIND_LINE;
        n_entry.c1x  = i_cmd.ctrl1_x;
        n_entry.c1y  = i_cmd.ctrl1_y;
        n_entry.c2x  = i_cmd.ctrl2_x;
        n_entry.c2y  = i_cmd.ctrl2_y;
        n_entry.ex   = i_cmd.end_x;
        n_entry.ey   = i_cmd.end_y;
        n_valid_op   = 1'b1;
        case (i_cmd.opcode)
            OP_BEGIN: n_entry.cls = CLS_BEGIN;
            OP_MOVE: begin
                n_entry.cls  = CLS_POINT;
                n_entry.kind = KIND_MOVE;
            end
            OP_LINE:  n_entry.cls = CLS_POINT;
            OP_QUAD:  n_entry.cls = CLS_QUAD;
            OP_CUBIC: n_entry.cls = CLS_CUBIC;
            default: begin
                n_entry.cls = CLS_BEGIN;
                n_valid_op  = 1'b0;
            end
        endcase
    end

    assign i_cmd.ready = (r_fill != FILL_W'(DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready && n_valid_op;
    assign o_head_v    = (r_fill != '0);
    assign o_head      = r_q[r_rp];
    assign pop         = i_pop && o_head_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_entry;
        end
    end

endmodule

// ===== sv/bpf_back.sv =====
// Back end: sequences samples of each command through a weight/multiply/sum/round pipeline,
// keeps the last stored point and the point count. Depends on bpf_pkg and bpf_pt_if.
module bpf_back import bpf_pkg::*; #(
    parameter int MAX_POINTS  = 5000,
    parameter int QUAD_STEPS  = 16,
    parameter int CUBIC_STEPS = 24
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_head_v,
    input  t_cmd     i_head,
    output logic     o_pop,
    bpf_pt_if.source o_pt
);

    localparam int MAX_STEP = (QUAD_STEPS > CUBIC_STEPS) ? QUAD_STEPS : CUBIC_STEPS;
    localparam int STEP_W   = $clog2(MAX_STEP);
    localparam int QI_W     = $clog2(QUAD_STEPS);
    localparam int CI_W     = $clog2(CUBIC_STEPS);
    localparam longint QDEN = longint'(QUAD_STEPS) * QUAD_STEPS;
    localparam longint CDEN = longint'(CUBIC_STEPS) * CUBIC_STEPS * CUBIC_STEPS;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_POINTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [WGT_W-1:0] q_w0 [QUAD_STEPS];
    logic [WGT_W-1:0] q_w1 [QUAD_STEPS];
    logic [WGT_W-1:0] q_w2 [QUAD_STEPS];
    logic [WGT_W-1:0] c_w0 [CUBIC_STEPS];
    logic [WGT_W-1:0] c_w1 [CUBIC_STEPS];
    logic [WGT_W-1:0] c_w2 [CUBIC_STEPS];
    logic [WGT_W-1:0] c_w3 [CUBIC_STEPS];

    for (genvar g = 0; g < QUAD_STEPS; g++) begin : g_qw
        localparam longint I  = longint'(g) + 1;
        localparam longint M  = longint'(QUAD_STEPS) - I;
        localparam longint W0 = (M * M * WGT_SCALE + QDEN / 2) / QDEN;
        localparam longint W1 = (2 * M * I * WGT_SCALE + QDEN / 2) / QDEN;
        localparam longint W2 = (I * I * WGT_SCALE + QDEN / 2) / QDEN;
        assign q_w0[g] = WGT_W'(W0);
        assign q_w1[g] = WGT_W'(W1);
        assign q_w2[g] = WGT_W'(W2);
    end

    for (genvar g = 0; g < CUBIC_STEPS; g++) begin : g_cw
        localparam longint I  = longint'(g) + 1;
        localparam longint M  = longint'(CUBIC_STEPS) - I;
        localparam longint W0 = (M * M * M * WGT_SCALE + CDEN / 2) / CDEN;
        localparam longint W1 = (3 * M * M * I * WGT_SCALE + CDEN / 2) / CDEN;
        localparam longint W2 = (3 * M * I * I * WGT_SCALE + CDEN / 2) / CDEN;
        localparam longint W3 = (I * I * I * WGT_SCALE + CDEN / 2) / CDEN;
        assign c_w0[g] = WGT_W'(W0);
        assign c_w1[g] = WGT_W'(W1);
        assign c_w2[g] = WGT_W'(W2);
        assign c_w3[g] = WGT_W'(W3);
    end

    logic                     r_state;
    logic                     n_state;
    t_cls                     r_cls;
    logic                     r_kind;
    logic [STEP_W-1:0]        r_step;
    logic [CNT_W-1:0]         r_count;
    logic                     r_has;
    t_coord                   r_last_x;
    t_coord                   r_last_y;
    t_coord                   r_tx [NTERM];
    t_coord                   r_ty [NTERM];

    logic                     r_s0_v;
    logic [WGT_W-1:0]         r_s0_w [NTERM];
    logic                     r_s0_kind;
    logic                     r_s0_last;
    logic                     r_s1_v;
    logic signed [PROD_W-1:0] r_s1_px [NTERM];
    logic signed [PROD_W-1:0] r_s1_py [NTERM];
    logic                     r_s1_kind;
    logic                     r_s1_last;
    logic                     r_s2_v;
    logic signed [SUM_W-1:0]  r_s2_sx;
    logic signed [SUM_W-1:0]  r_s2_sy;
    logic                     r_s2_kind;
    logic                     r_s2_last;
    logic                     r_o_v;
    t_coord                   r_o_x;
    t_coord                   r_o_y;
    logic                     r_o_kind;
    logic                     r_o_last;

    logic                     adv;
    logic                     busy;
    logic                     issue;
    logic                     last_step;
    logic                     pt_last;
    logic [WGT_W-1:0]         wsel [NTERM];
    logic [QI_W-1:0]          qi;
    logic [CI_W-1:0]          ci;

    function automatic t_coord f_round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0]          b;
        logic signed [SUM_W-WGT_FRAC:0] q;
        b = {s[SUM_W-1], s} + (SUM_W + 1)'(WGT_SCALE / 2);
        q = b[SUM_W:WGT_FRAC];
        if (q > (SUM_W - WGT_FRAC + 1)'(64'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (q < -(SUM_W - WGT_FRAC + 1)'(64'sh80000000)) begin
            return 32'sh80000000;
        end
        return q[COORD_W-1:0];
    endfunction

    assign adv  = !r_o_v || o_pt.ready;
    assign busy = r_s0_v || r_s1_v || r_s2_v;
    assign o_pop = (r_state == ST_IDLE) && i_head_v && !busy;
    assign qi = r_step[QI_W-1:0];
    assign ci = r_step[CI_W-1:0];
    assign issue = (r_state == ST_RUN) && adv;

    always_comb begin
        case (r_cls)
            CLS_QUAD: begin
                last_step = (r_step == STEP_W'(QUAD_STEPS - 1));
                wsel[0] = q_w0[qi];
                wsel[1] = q_w1[qi];
                wsel[2] = WGT_ZERO;
                wsel[3] = q_w2[qi];
            end
            CLS_CUBIC: begin
                last_step = (r_step == STEP_W'(CUBIC_STEPS - 1));
                wsel[0] = c_w0[ci];
                wsel[1] = c_w1[ci];
                wsel[2] = c_w2[ci];
                wsel[3] = c_w3[ci];
            end
            default: begin
                last_step = 1'b1;
                wsel[0] = WGT_ZERO;
                wsel[1] = WGT_ZERO;
                wsel[2] = WGT_ZERO;
                wsel[3] = WGT_ONE;
            end
        endcase
        pt_last = last_step || (r_count + CNT_W'(1) == LIMIT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_head.cls != CLS_BEGIN && r_count < LIMIT) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue && pt_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_has    <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_s0_v   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_head.cls == CLS_BEGIN) begin
                r_count  <= '0;
                r_has    <= 1'b0;
                r_last_x <= '0;
                r_last_y <= '0;
            end
            if (issue) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (adv) begin
                r_s0_v <= issue;
                r_s1_v <= r_s0_v;
                r_s2_v <= r_s1_v;
                r_o_v  <= r_s2_v;
                if (r_s2_v) begin
                    r_has    <= 1'b1;
                    r_last_x <= f_round_sat(r_s2_sx);
                    r_last_y <= f_round_sat(r_s2_sy);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cls   <= i_head.cls;
            r_kind  <= i_head.kind;
            r_step  <= '0;
            r_tx[0] <= r_has ? r_last_x : i_head.c1x;
            r_ty[0] <= r_has ? r_last_y : i_head.c1y;
            r_tx[1] <= i_head.c1x;
            r_ty[1] <= i_head.c1y;
            r_tx[2] <= i_head.c2x;
            r_ty[2] <= i_head.c2y;
            r_tx[3] <= i_head.ex;
            r_ty[3] <= i_head.ey;
        end else if (issue) begin
            r_step <= r_step + STEP_W'(1);
        end
        if (adv) begin
            r_s0_w    <= wsel;
            r_s0_kind <= r_kind;
            r_s0_last <= pt_last;
            for (int k = 0; k < NTERM; k++) begin
                r_s1_px[k] <= $signed({1'b0, r_s0_w[k]}) * r_tx[k];
                r_s1_py[k] <= $signed({1'b0, r_s0_w[k]}) * r_ty[k];
            end
            r_s1_kind <= r_s0_kind;
            r_s1_last <= r_s0_last;
            r_s2_sx   <= SUM_W'(r_s1_px[0]) + SUM_W'(r_s1_px[1])
                       + SUM_W'(r_s1_px[2]) + SUM_W'(r_s1_px[3]);
            r_s2_sy   <= SUM_W'(r_s1_py[0]) + SUM_W'(r_s1_py[1])
                       + SUM_W'(r_s1_py[2]) + SUM_W'(r_s1_py[3]);
            r_s2_kind <= r_s1_kind;
            r_s2_last <= r_s1_last;
            r_o_x     <= f_round_sat(r_s2_sx);
            r_o_y     <= f_round_sat(r_s2_sy);
            r_o_kind  <= r_s2_kind;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_pt.valid      = r_o_v;
    assign o_pt.point_x    = r_o_x;
    assign o_pt.point_y    = r_o_y;
    assign o_pt.point_kind = r_o_kind;
    assign o_pt.last_point = r_o_last;

endmodule

// ===== sv/bezier_path_flattener.sv =====
// Bezier path flattener: turns path commands (begin, move, line, quadratic, cubic) in signed
// Q16.16 into path points, each tagged move or line, with the last point of a command marked.
// A quadratic yields QUAD_STEPS points and a cubic CUBIC_STEPS points sampled at t = i/N,
// starting from the last stored point (or the first control point on an empty path); points
// beyond MAX_POINTS are dropped until the next begin. Commands queue in a two-entry buffer;
// the sample sequencer issues one point per cycle, while the point receiver is not stalling,
// into a four-stage weight, multiply, sum and round pipeline. A command starts only after the
// previous one has cleared the sum stage; a begin, an ignored opcode (5 to 7) or a command
// past the limit yields no point.
// Depends on bpf_pkg, bpf_cmd_if, bpf_pt_if, bpf_front and bpf_back.
module bezier_path_flattener import bpf_pkg::*; #(
    parameter int MAX_POINTS  = 5000,
    parameter int QUAD_STEPS  = 16,
    parameter int CUBIC_STEPS = 24
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bpf_cmd_if.sink  i_cmd,
    bpf_pt_if.source o_pt
);

    logic head_v;
    t_cmd head;
    logic pop;

    bpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .o_head_v (head_v),
        .o_head   (head),
        .i_pop    (pop)
    );

    bpf_back #(
        .MAX_POINTS  (MAX_POINTS),
        .QUAD_STEPS  (QUAD_STEPS),
        .CUBIC_STEPS (CUBIC_STEPS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head_v (head_v),
        .i_head   (head),
        .o_pop    (pop),
        .o_pt     (o_pt)
    );

endmodule
